// ===== rtl/kpc_pkg.sv =====
// Shared types and constants for the key press classifier.
`default_nettype none

package kpc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CodeWidth  = 8;
   localparam int unsigned ThrWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [CodeWidth-1:0] ReleaseMark = 8'h80;

   // Register indexes on the control port.
   localparam logic [CsrIdxWidth-1:0] CsrShortPress = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLongPress  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLongMask   = 2'd2;

   localparam logic [ThrWidth-1:0]  ShortPressReset = 16'd50;
   localparam logic [ThrWidth-1:0]  LongPressReset  = 16'd1000;
   localparam logic [CodeWidth-1:0] LongMaskReset   = 8'd64;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_DOWN     = 4'b0010,
      PH_HELD     = 4'b0100,
      PH_RELEASED = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [ThrWidth-1:0]  short_press_ms;
      logic [ThrWidth-1:0]  long_press_ms;
      logic [CodeWidth-1:0] long_press_mask;
   } cfg_type;

   typedef struct packed {
      logic                 any_pressed;
      logic [CodeWidth-1:0] key_code;
      logic [TimeWidth-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [CodeWidth-1:0] key_event;
      logic [CodeWidth-1:0] led_code;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/kpc_if.sv =====
// Channel interfaces for the key press classifier: scan calls, results, control writes.
`default_nettype none

interface kpc_req_if;
   logic        valid;
   logic        ready;
   logic        any_pressed;
   logic [7:0]  key_code;
   logic [31:0] now_ms;

   modport source (output valid, output any_pressed, output key_code, output now_ms,
                   input ready);
   modport sink   (input valid, input any_pressed, input key_code, input now_ms,
                   output ready);
endinterface

interface kpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_event;
   logic [7:0] led_code;

   modport source (output valid, output key_event, output led_code, input ready);
   modport sink   (input valid, input key_event, input led_code, output ready);
endinterface

interface kpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kpc_cfg.sv =====
// Control registers: press thresholds and long press mask.
`default_nettype none

module kpc_cfg (
   input  wire logic             clock,
   input  wire logic             reset,
   kpc_csr_if.sink               csr_bus,
   output kpc_pkg::cfg_type      cfg
);
   import kpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CsrShortPress: cfg_in.short_press_ms  = csr_bus.data;
            CsrLongPress:  cfg_in.long_press_ms   = csr_bus.data;
            CsrLongMask:   cfg_in.long_press_mask = csr_bus.data[CodeWidth-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press_ms  <= ShortPressReset;
         cfg_ff.long_press_ms   <= LongPressReset;
         cfg_ff.long_press_mask <= LongMaskReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/kpc_core.sv =====
// Press state machine: phase, time stamp, latched code and event update per scan call.
`default_nettype none

module kpc_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire kpc_pkg::item_type   item,
   input  wire kpc_pkg::cfg_type    cfg,
   output kpc_pkg::result_type      result
);
   import kpc_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [TimeWidth-1:0] stamp_ff, stamp_in;
   logic [CodeWidth-1:0] held_ff, held_in;
   logic                 armed_ff, armed_in;
   logic [CodeWidth-1:0] event_ff, event_in;
   logic [CodeWidth-1:0] disp_ff, disp_in;
   phase_type            phase_mid;
   logic [TimeWidth-1:0] held_time;
   logic                 reached_long;
   logic                 reached_short;

   // Hold time wraps with the millisecond counter. It is only used in the held and
   // released phases, which a fresh press never reaches in the same call, so the
   // stored stamp is the one that applies.
   assign held_time     = item.now_ms - stamp_ff;
   assign reached_long  = held_time >= TimeWidth'(cfg.long_press_ms);
   assign reached_short = held_time >= TimeWidth'(cfg.short_press_ms);

   always_comb begin
      phase_mid = phase_ff;
      stamp_in  = stamp_ff;
      held_in   = held_ff;
      armed_in  = armed_ff;
      event_in  = event_ff;
      disp_in   = disp_ff;

      case (phase_ff)
         PH_IDLE: begin
            event_in = '0;
            if (item.any_pressed) begin
               armed_in  = 1'b0;
               phase_mid = PH_DOWN;
               stamp_in  = item.now_ms;
            end
         end
         PH_DOWN: begin
            if (!armed_ff) begin
               armed_in  = 1'b1;
               held_in   = item.key_code;
               phase_mid = PH_HELD;
            end
         end
         PH_HELD: begin
            if (!item.any_pressed) begin
               phase_mid = PH_RELEASED;
            end
         end
         default: phase_mid = phase_ff;
      endcase

      phase_in = phase_mid;
      case (phase_mid)
         PH_HELD: begin
            disp_in = held_in;
            if (reached_long && armed_in) begin
               armed_in = 1'b0;
               event_in = held_in | cfg.long_press_mask;
            end else begin
               event_in = '0;
            end
         end
         PH_RELEASED: begin
            phase_in = PH_IDLE;
            stamp_in = '0;
            if (reached_short && !reached_long) begin
               event_in = held_in;
            end
            held_in = '0;
            disp_in = disp_ff | ReleaseMark;
         end
         default: phase_in = phase_mid;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stamp_ff <= '0;
         held_ff  <= '0;
         armed_ff <= 1'b0;
         event_ff <= '0;
         disp_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         stamp_ff <= stamp_in;
         held_ff  <= held_in;
         armed_ff <= armed_in;
         event_ff <= event_in;
         disp_ff  <= disp_in;
      end
   end

   assign result.key_event = event_in;
   assign result.led_code  = disp_in;

endmodule

`default_nettype wire

// ===== rtl/key_press_classifier_unit.sv =====
// Top level of the key press classifier: input register, press state machine, result register.
//
//   channel   | direction | payload                          | transfer when
//   ----------+-----------+----------------------------------+---------------------------
//   req_bus   | in        | any_pressed, key_code, now_ms    | valid && ready
//   rsp_bus   | out       | key_event, led_code              | valid && ready
//   csr_bus   | in        | index (0 short, 1 long, 2 mask)  | valid (ready is always 1)
//
// A scan call is registered on arrival in the input register and evaluated there once it can
// advance, which loads its result into the result register and raises rsp_bus.valid. One call
// per cycle is sustained while rsp_bus.ready is high; one call's state update feeds the next call.
// A stalled result register holds the staged call, and req_bus.ready drops only while both
// the staged call and the result are waiting. Synchronous reset clears state and valid flags.
`default_nettype none

module key_press_classifier_unit (
   input  wire logic clock,
   input  wire logic reset,
   kpc_req_if.sink   req_bus,
   kpc_rsp_if.source rsp_bus,
   kpc_csr_if.sink   csr_bus
);
   import kpc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_fire;

   // The staged call moves on whenever the result register is free or draining.
   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_fire = req_bus.valid && req_bus.ready;

   kpc_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   kpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.any_pressed <= req_bus.any_pressed;
         item_ff.key_code    <= req_bus.key_code;
         item_ff.now_ms      <= req_bus.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.key_event = rsp_ff.key_event;
   assign rsp_bus.led_code  = rsp_ff.led_code;

endmodule

`default_nettype wire
